// File: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Holds the command, status and state codes and the transfer structs.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // Widths of the byte counts that travel on the ports.
   localparam int SIZE_W = 23;
   localparam int FREE_W = 22;
   localparam int HEADER_BYTES = 12;
   // Largest leftover that is handed out with the block instead of split off.
   localparam int SPLIT_LIMIT = HEADER_BYTES + 1;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOMEM    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_NOSLOT   = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] request_size;
      logic [FREE_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SIZE_W-1:0] payload_offset;
   } rsp_type;

   // One block of the chain, without its link (its width follows the table depth).
   typedef struct packed {
      logic              used;
      logic              has_next;
      logic [SIZE_W-1:0] offset;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_SCAN,
      S_SPLIT,
      S_NREAD,
      S_NEVAL
   } state_type;

endpackage

// File: rtl/core/ffha_table.sv
// ----------------------------------------------------------------------------
// ffha_table: block table memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ffha_table #(
   parameter int MAX_BLOCKS = 256,
   parameter int IW = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_addr,
   input  ffha_pkg::entry_type  wr_entry,
   input  logic [IW-1:0]        wr_next,
   input  logic [IW-1:0]        rd_addr,
   output ffha_pkg::entry_type  rd_entry,
   output logic [IW-1:0]        rd_next
);

   ffha_pkg::entry_type entry_mem [MAX_BLOCKS];
   logic [IW-1:0]       next_mem [MAX_BLOCKS];

   // Write the addressed entry and its link.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
         next_mem[wr_addr]  <= wr_next;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      rd_entry <= entry_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
   end

endmodule

// File: rtl/core/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with split/coalesce
// Walks an address-ordered block chain held in a table memory.
// ----------------------------------------------------------------------------
// Usage: a command transfers at a rising edge with start high and busy low.
// Allocate (cmd 0) returns the payload offset of the first free block that
// fits; free (cmd 1) releases the used block whose payload is free_offset and
// merges it with a free next block. Each command gives one result, shown on
// rsp for one cycle with rsp_valid high; the receiver cannot stall it.
// Walk: each chain block visited takes a table read and an evaluate step
// (S_READ, S_EVAL). A split adds a scan of the valid bits for a spare slot,
// one slot per cycle, then the S_SPLIT write; a free whose block has a next
// block adds a read and an evaluate of that block. Busy stays high through
// the result cycle. After reset the block writes the initial heap block
// into slot 0 in S_INIT, with busy high.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES = 4194304,
   parameter int MAX_BLOCKS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ffha_pkg::req_type req,
   output logic              busy,
   output logic              rsp_valid,
   output ffha_pkg::rsp_type rsp
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int SW = ffha_pkg::SIZE_W;

   ffha_pkg::state_type state_ff, state_in;
   logic [MAX_BLOCKS-1:0] valid_ff, valid_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [IW-1:0]         scan_ff, scan_in;
   logic [IW-1:0]         spare_ff, spare_in;
   ffha_pkg::entry_type   blk_ff, blk_in;
   logic [IW-1:0]         blk_next_ff, blk_next_in;
   logic                  cmd_ff, cmd_in;
   logic [SW-1:0]         req_ff, req_in;
   logic [SW-1:0]         hdr_ff, hdr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   ffha_pkg::entry_type   wr_entry;
   logic [IW-1:0]         wr_next;
   logic [IW-1:0]         rd_addr;
   ffha_pkg::entry_type   rd_entry;
   logic [IW-1:0]         rd_next;

   ffha_table #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .IW         (IW)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .wr_next  (wr_next),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_next  (rd_next)
   );

   // Decisions on the entry just read and on the scan position.
   logic          accept;
   logic          early_miss;
   logic          cur_valid;
   logic          fit;
   logic          need_split;
   logic          match;
   logic          spare_hit;
   logic          scan_last;
   logic          merge;
   logic [SW-1:0] left;
   logic [SW-1:0] blk_left;

   assign accept     = start && !busy;
   assign early_miss = (req.cmd == ffha_pkg::CMD_FREE) &&
                       (req.free_offset < ffha_pkg::FREE_W'(ffha_pkg::HEADER_BYTES));
   assign cur_valid  = valid_ff[cur_ff];
   assign fit        = !rd_entry.used && (rd_entry.size >= req_ff);
   assign left       = rd_entry.size - req_ff;
   assign need_split = left > SW'(ffha_pkg::SPLIT_LIMIT);
   assign match      = rd_entry.used && (rd_entry.offset == hdr_ff);
   assign spare_hit  = !valid_ff[scan_ff];
   assign scan_last  = scan_ff == IW'(MAX_BLOCKS - 1);
   assign merge      = valid_ff[blk_next_ff] && !rd_entry.used;
   assign blk_left   = blk_ff.size - req_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffha_pkg::S_INIT: state_in = ffha_pkg::S_IDLE;
         ffha_pkg::S_IDLE: begin
            if (accept && !early_miss) state_in = ffha_pkg::S_READ;
         end
         ffha_pkg::S_READ: state_in = ffha_pkg::S_EVAL;
         ffha_pkg::S_EVAL: begin
            if (!cur_valid) begin
               state_in = ffha_pkg::S_IDLE;
            end else if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               if (fit && need_split) state_in = ffha_pkg::S_SCAN;
               else if (fit || !rd_entry.has_next) state_in = ffha_pkg::S_IDLE;
               else state_in = ffha_pkg::S_READ;
            end else begin
               if (match && rd_entry.has_next) state_in = ffha_pkg::S_NREAD;
               else if (match || !rd_entry.has_next) state_in = ffha_pkg::S_IDLE;
               else state_in = ffha_pkg::S_READ;
            end
         end
         ffha_pkg::S_SCAN: begin
            if (spare_hit) state_in = ffha_pkg::S_SPLIT;
            else if (scan_last) state_in = ffha_pkg::S_IDLE;
         end
         ffha_pkg::S_SPLIT: state_in = ffha_pkg::S_IDLE;
         ffha_pkg::S_NREAD: state_in = ffha_pkg::S_NEVAL;
         ffha_pkg::S_NEVAL: state_in = ffha_pkg::S_IDLE;
         default:           state_in = ffha_pkg::S_INIT;
      endcase
   end

   // Datapath, table accesses and results.
   always_comb begin
      valid_in     = valid_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      spare_in     = spare_ff;
      blk_in       = blk_ff;
      blk_next_in  = blk_next_ff;
      cmd_in       = cmd_ff;
      req_in       = req_ff;
      hdr_in       = hdr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_entry     = blk_ff;
      wr_next      = blk_next_ff;
      rd_addr      = cur_ff;
      case (state_ff)
         ffha_pkg::S_INIT: begin
            // Slot 0 holds the whole heap less one header.
            wr_en             = 1'b1;
            wr_addr           = '0;
            wr_entry.used     = 1'b0;
            wr_entry.has_next = 1'b0;
            wr_entry.offset   = '0;
            wr_entry.size     = SW'(HEAP_BYTES - ffha_pkg::HEADER_BYTES);
            wr_next           = '0;
         end
         ffha_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in = req.cmd;
               req_in = req.request_size;
               hdr_in = SW'(req.free_offset) - SW'(ffha_pkg::HEADER_BYTES);
               cur_in = '0;
               if (early_miss) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ffha_pkg::ST_NOTFOUND, payload_offset: '0};
               end
            end
         end
         ffha_pkg::S_EVAL: begin
            blk_in      = rd_entry;
            blk_next_in = rd_next;
            rsp_in      = '{status: ffha_pkg::ST_OK, payload_offset: '0};
            if (!cur_valid) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = (cmd_ff == ffha_pkg::CMD_ALLOC) ? ffha_pkg::ST_NOMEM
                                                               : ffha_pkg::ST_NOTFOUND;
            end else if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               if (fit && need_split) begin
                  scan_in = '0;
               end else if (fit) begin
                  wr_en                 = 1'b1;
                  wr_entry              = rd_entry;
                  wr_entry.used         = 1'b1;
                  wr_next               = rd_next;
                  rsp_valid_in          = 1'b1;
                  rsp_in.payload_offset = rd_entry.offset + SW'(ffha_pkg::HEADER_BYTES);
               end else if (!rd_entry.has_next) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ffha_pkg::ST_NOMEM;
               end else begin
                  cur_in = rd_next;
               end
            end else begin
               if (match && rd_entry.has_next) begin
                  // Keep cur_ff; the next block is read for a possible merge.
               end else if (match) begin
                  wr_en         = 1'b1;
                  wr_entry      = rd_entry;
                  wr_entry.used = 1'b0;
                  wr_next       = rd_next;
                  rsp_valid_in  = 1'b1;
               end else if (!rd_entry.has_next) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ffha_pkg::ST_NOTFOUND;
               end else begin
                  cur_in = rd_next;
               end
            end
         end
         ffha_pkg::S_SCAN: begin
            // Lowest invalid slot receives the free remainder.
            if (spare_hit) begin
               wr_en             = 1'b1;
               wr_addr           = scan_ff;
               wr_entry.used     = 1'b0;
               wr_entry.has_next = blk_ff.has_next;
               wr_entry.offset   = blk_ff.offset + req_ff + SW'(ffha_pkg::HEADER_BYTES);
               wr_entry.size     = blk_left - SW'(ffha_pkg::HEADER_BYTES);
               wr_next           = blk_next_ff;
               valid_in[scan_ff] = 1'b1;
               spare_in          = scan_ff;
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ffha_pkg::ST_NOSLOT, payload_offset: '0};
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         ffha_pkg::S_SPLIT: begin
            wr_en             = 1'b1;
            wr_entry.used     = 1'b1;
            wr_entry.has_next = 1'b1;
            wr_entry.size     = req_ff;
            wr_next           = spare_ff;
            rsp_valid_in      = 1'b1;
            rsp_in            = '{status: ffha_pkg::ST_OK,
                                  payload_offset: blk_ff.offset +
                                                  SW'(ffha_pkg::HEADER_BYTES)};
         end
         ffha_pkg::S_NREAD: begin
            rd_addr = blk_next_ff;
         end
         ffha_pkg::S_NEVAL: begin
            // Release the block and absorb a free next block, header included.
            wr_en         = 1'b1;
            wr_entry.used = 1'b0;
            if (merge) begin
               wr_entry.size         = blk_ff.size + rd_entry.size +
                                       SW'(ffha_pkg::HEADER_BYTES);
               wr_entry.has_next     = rd_entry.has_next;
               wr_next               = rd_next;
               valid_in[blk_next_ff] = 1'b0;
            end
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ffha_pkg::ST_OK, payload_offset: '0};
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_INIT;
         valid_ff     <= MAX_BLOCKS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      spare_ff    <= spare_in;
      blk_ff      <= blk_in;
      blk_next_ff <= blk_next_in;
      cmd_ff      <= cmd_in;
      req_ff      <= req_in;
      hdr_ff      <= hdr_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ffha_pkg::S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Slot 0 heads the chain and is never released.
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff != ffha_pkg::S_INIT |-> valid_ff[0])
      else $error("chain head slot lost its valid bit");

   // An accepted command keeps the unit busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("unit not busy after a command transfer");

   // A failed command reports a zero offset.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ffha_pkg::ST_OK) |-> rsp.payload_offset == '0)
      else $error("failed command with nonzero offset");

   // A result ends the command: the unit is idle while it is shown.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ffha_pkg::S_IDLE)
      else $error("result shown while a command is still at work");

endmodule
